/* rtl/tnda_pkg.sv */
// Shared constants and types for the toroidal N-dimensional word store.
`default_nettype none
package tnda_pkg;
    localparam int CELLS    = 4096;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int MAX_DIMS = 7;
    localparam int DIM_W    = 3;
    localparam int SIZE_W   = 13;
    localparam int WORD_W   = 32;
    localparam int TOT_W    = $clog2(CELLS) + 1;

    // Request type bit positions.
    localparam int REQ_WRITE_BIT = 0;
    localparam int REQ_WRAP_BIT  = 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [2:0] REG_DIM_SIZE_0 = 3'd1;

    typedef logic [MAX_DIMS-1:0][SIZE_W-1:0] size_arr_t;
    typedef logic [MAX_DIMS-1:0][WORD_W-1:0] pos_arr_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic              is_write;
        pos_arr_t          pos;
        logic [WORD_W-1:0] wdata;
    } entry_t;

    // Number of dimensions actually used; zero counts as one.
    function automatic logic [DIM_W-1:0] used_dims(input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] r;
        r = (n == '0) ? DIM_W'(1) : n;
        if (r > DIM_W'(MAX_DIMS))
        begin
            r = DIM_W'(MAX_DIMS);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/toroidal_nd_array_access_top.sv */
// Top level of the toroidal N-dimensional word store.
//
// Configuration: write cfg_data to register cfg_index while cfg_wr_en is high
// (0 is the dimension count, 1 to 7 the dimension sizes), only while idle.
// Requests arrive on the in_valid/in_ready channel; each transfer gives exactly
// one result transfer on out_valid/out_ready with read_data and status.
// A plain read passes the front, the queue and the back's pick-up, then one
// multiply and one check step per dimension, then a store step and a read step;
// a write or a request rejected at the store step skips the read step, and one
// that overflows in a check step goes straight to the result.
// A wrapped request first passes each used dimension in turn through the shared
// bit-serial modulo unit of the front end.
// A two-entry queue sits between front and back, so the front takes and reduces
// the next request while a result waits.
// After reset the store is cleared one word a cycle, all 4096 words, before the
// first request is carried out; requests are still taken into the queue.
// When the receiver stalls, the result holds and the queue fills, then
// in_ready drops.
`default_nettype none
module toroidal_nd_array_access_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [12:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           req_type,
    input  wire logic signed [31:0]   index_0,
    input  wire logic signed [31:0]   index_1,
    input  wire logic signed [31:0]   index_2,
    input  wire logic signed [31:0]   index_3,
    input  wire logic signed [31:0]   index_4,
    input  wire logic signed [31:0]   index_5,
    input  wire logic signed [31:0]   index_6,
    input  wire logic [31:0]          write_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               read_data,
    output logic                      status
);
    logic [tnda_pkg::DIM_W-1:0] num_dims_reg;
    tnda_pkg::size_arr_t        sizes_reg;
    tnda_pkg::pos_arr_t         index_in;
    tnda_pkg::entry_t           push_entry, pop_entry;
    logic                       push_valid, push_ready, pop_valid, pop_ready;

    assign index_in = {index_6, index_5, index_4, index_3, index_2, index_1, index_0};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= tnda_pkg::DIM_W'(1);
            sizes_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == tnda_pkg::REG_NUM_DIMS)
            begin
                num_dims_reg <= cfg_data[tnda_pkg::DIM_W-1:0];
            end
            else
            begin
                sizes_reg[cfg_index - tnda_pkg::REG_DIM_SIZE_0] <= cfg_data;
            end
        end
    end

    tnda_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_dims    (num_dims_reg),
        .sizes       (sizes_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .index_in    (index_in),
        .write_value (write_value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    tnda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    tnda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_dims  (num_dims_reg),
        .sizes     (sizes_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .status    (status)
    );
endmodule
`default_nettype wire

/* rtl/tnda_front.sv */
// Front end: accepts requests and reduces wrapped indices with a bit-serial modulo unit.
`default_nettype none
module tnda_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [tnda_pkg::DIM_W-1:0]        num_dims,
    input  wire tnda_pkg::size_arr_t               sizes,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        req_type,
    input  wire tnda_pkg::pos_arr_t                index_in,
    input  wire logic [tnda_pkg::WORD_W-1:0]       write_value,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output tnda_pkg::entry_t                       push_entry
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                              state_reg, state_next;
    tnda_pkg::entry_t                     entry_reg, entry_next;
    logic [tnda_pkg::DIM_W-1:0]           dim_reg, dim_next;
    logic [4:0]                           cnt_reg, cnt_next;
    logic [tnda_pkg::WORD_W-1:0]          mag_reg, mag_next;
    logic [tnda_pkg::SIZE_W-1:0]          rem_reg, rem_next;
    logic                                 neg_reg, neg_next;
    logic [tnda_pkg::DIM_W-1:0]           last_dim;
    logic [tnda_pkg::SIZE_W-1:0]          dsize;
    logic [tnda_pkg::SIZE_W:0]            trial;
    logic [tnda_pkg::SIZE_W-1:0]          rem_step;
    logic [tnda_pkg::SIZE_W-1:0]          rem_final;
    logic [tnda_pkg::WORD_W-1:0]          next_raw;
    logic [tnda_pkg::DIM_W-1:0]           dim_inc;

    assign last_dim = tnda_pkg::used_dims(num_dims) - tnda_pkg::DIM_W'(1);
    assign dsize    = sizes[dim_reg];
    assign dim_inc  = dim_reg + tnda_pkg::DIM_W'(1);

    // One restoring step of the remainder per cycle.
    always_comb
    begin
        trial = {rem_reg, mag_reg[tnda_pkg::WORD_W-1]};
        if (trial >= {1'b0, dsize})
        begin
            rem_step = tnda_pkg::SIZE_W'(trial - {1'b0, dsize});
        end
        else
        begin
            rem_step = trial[tnda_pkg::SIZE_W-1:0];
        end
        if (dsize == '0)
        begin
            rem_final = '0;
        end
        else if (neg_reg && rem_step != '0)
        begin
            rem_final = dsize - rem_step;
        end
        else
        begin
            rem_final = rem_step;
        end
        next_raw = entry_reg.pos[(dim_reg == tnda_pkg::DIM_W'(tnda_pkg::MAX_DIMS - 1)) ?
                                 dim_reg : dim_inc];
    end

    // Sequencer for accept, modulo and hand-off.
    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        dim_next   = dim_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        in_ready   = (state_reg == F_IDLE);
        push_valid = (state_reg == F_PUSH);
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    entry_next.is_write = req_type[tnda_pkg::REQ_WRITE_BIT];
                    entry_next.pos      = index_in;
                    entry_next.wdata    = write_value;
                    dim_next            = '0;
                    cnt_next            = '0;
                    rem_next            = '0;
                    neg_next            = index_in[0][tnda_pkg::WORD_W-1];
                    mag_next            = index_in[0][tnda_pkg::WORD_W-1] ?
                                          (~index_in[0] + 1'b1) : index_in[0];
                    state_next = req_type[tnda_pkg::REQ_WRAP_BIT] ? F_DIV : F_PUSH;
                end
            end
            F_DIV:
            begin
                mag_next = {mag_reg[tnda_pkg::WORD_W-2:0], 1'b0};
                rem_next = rem_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    entry_next.pos[dim_reg] = tnda_pkg::WORD_W'(rem_final);
                    cnt_next = '0;
                    rem_next = '0;
                    if (dim_reg == last_dim)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        dim_next = dim_inc;
                        neg_next = next_raw[tnda_pkg::WORD_W-1];
                        mag_next = next_raw[tnda_pkg::WORD_W-1] ? (~next_raw + 1'b1) : next_raw;
                    end
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_entry = entry_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            dim_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
    end
endmodule
`default_nettype wire

/* rtl/tnda_queue.sv */
// Two-entry queue that decouples the front end from the back end.
`default_nettype none
module tnda_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire tnda_pkg::entry_t push_entry,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output tnda_pkg::entry_t      pop_entry
);
    tnda_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill tracking.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end
endmodule
`default_nettype wire

/* rtl/tnda_back.sv */
// Back end: row-major flattening with overflow checks, word store and result register.
`default_nettype none
module tnda_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tnda_pkg::DIM_W-1:0]    num_dims,
    input  wire tnda_pkg::size_arr_t           sizes,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire tnda_pkg::entry_t              pop_entry,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tnda_pkg::WORD_W-1:0]        read_data,
    output logic                               status
);
    typedef enum logic [6:0] {
        B_CLR  = 7'b0000001,
        B_IDLE = 7'b0000010,
        B_MUL  = 7'b0000100,
        B_ACC  = 7'b0001000,
        B_MEM  = 7'b0010000,
        B_RD   = 7'b0100000,
        B_OUT  = 7'b1000000
    } bstate_t;

    localparam int NSTR_W = tnda_pkg::WORD_W + tnda_pkg::SIZE_W;
    localparam int NTOT_W = tnda_pkg::TOT_W + tnda_pkg::SIZE_W;

    bstate_t                           state_reg, state_next;
    logic [tnda_pkg::ADDR_W:0]         clr_reg, clr_next;
    tnda_pkg::entry_t                  cur_reg, cur_next;
    logic [tnda_pkg::DIM_W-1:0]        k_reg, k_next;
    logic [tnda_pkg::WORD_W-1:0]       acc_reg, acc_next;
    logic [tnda_pkg::WORD_W-1:0]       stride_reg, stride_next;
    logic [tnda_pkg::TOT_W-1:0]        total_reg, total_next;
    logic [2*tnda_pkg::WORD_W-1:0]     term_reg, term_next;
    logic [NSTR_W-1:0]                 nstr_reg, nstr_next;
    logic [NTOT_W-1:0]                 ntot_reg, ntot_next;
    logic [tnda_pkg::WORD_W-1:0]       data_reg, data_next;
    logic                              status_reg, status_next;
    logic [tnda_pkg::WORD_W:0]         sum;
    logic [tnda_pkg::SIZE_W-1:0]       ksize;
    logic                              mem_we;
    logic [tnda_pkg::ADDR_W-1:0]       mem_addr;
    logic [tnda_pkg::WORD_W-1:0]       mem_wdata;
    logic [tnda_pkg::WORD_W-1:0]       mem [tnda_pkg::CELLS];
    logic [tnda_pkg::WORD_W-1:0]       mem_rd_reg;

    assign ksize     = sizes[k_reg];
    assign sum       = {1'b0, acc_reg} + {1'b0, term_reg[tnda_pkg::WORD_W-1:0]};
    assign pop_ready = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT);
    assign read_data = data_reg;
    assign status    = status_reg;

    // Sequencer: one multiply stage and one check stage per dimension.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        stride_next = stride_reg;
        total_next  = total_reg;
        term_next   = term_reg;
        nstr_next   = nstr_reg;
        ntot_next   = ntot_reg;
        data_next   = data_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_addr    = acc_reg[tnda_pkg::ADDR_W-1:0];
        mem_wdata   = cur_reg.wdata;
        unique case (state_reg)
            B_CLR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg[tnda_pkg::ADDR_W-1:0];
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (tnda_pkg::ADDR_W+1)'(tnda_pkg::CELLS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_next    = pop_entry;
                    k_next      = tnda_pkg::used_dims(num_dims) - tnda_pkg::DIM_W'(1);
                    acc_next    = '0;
                    stride_next = tnda_pkg::WORD_W'(1);
                    total_next  = tnda_pkg::TOT_W'(1);
                    state_next  = B_MUL;
                end
            end
            B_MUL:
            begin
                term_next  = cur_reg.pos[k_reg] * stride_reg;
                nstr_next  = stride_reg * ksize;
                ntot_next  = total_reg * ksize;
                state_next = B_ACC;
            end
            B_ACC:
            begin
                if (term_reg[2*tnda_pkg::WORD_W-1:tnda_pkg::WORD_W] != '0 ||
                    sum[tnda_pkg::WORD_W] ||
                    (k_reg != '0 && nstr_reg[NSTR_W-1:tnda_pkg::WORD_W] != '0))
                begin
                    data_next   = '0;
                    status_next = 1'b1;
                    state_next  = B_OUT;
                end
                else
                begin
                    acc_next    = sum[tnda_pkg::WORD_W-1:0];
                    stride_next = nstr_reg[tnda_pkg::WORD_W-1:0];
                    total_next  = (ntot_reg > NTOT_W'(tnda_pkg::CELLS)) ?
                                  tnda_pkg::TOT_W'(tnda_pkg::CELLS) :
                                  ntot_reg[tnda_pkg::TOT_W-1:0];
                    if (k_reg == '0)
                    begin
                        state_next = B_MEM;
                    end
                    else
                    begin
                        k_next     = k_reg - tnda_pkg::DIM_W'(1);
                        state_next = B_MUL;
                    end
                end
            end
            B_MEM:
            begin
                data_next = '0;
                if (acc_reg >= tnda_pkg::WORD_W'(total_reg) ||
                    acc_reg >= tnda_pkg::WORD_W'(tnda_pkg::CELLS))
                begin
                    status_next = 1'b1;
                    state_next  = B_OUT;
                end
                else
                begin
                    status_next = 1'b0;
                    mem_we      = cur_reg.is_write;
                    state_next  = cur_reg.is_write ? B_OUT : B_RD;
                end
            end
            B_RD:
            begin
                data_next  = mem_rd_reg;
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLR;
            clr_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        stride_reg <= stride_next;
        total_reg  <= total_next;
        term_reg   <= term_next;
        nstr_reg   <= nstr_next;
        ntot_reg   <= ntot_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    // Word store with one write port and a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_addr];
    end
endmodule
`default_nettype wire
